>>> rtl/strided_nd_address_walker_core_assert.svh
// assertion macros used by the walker core rtl
`ifndef STRIDED_ND_ADDRESS_WALKER_CORE_ASSERT_SVH
`define STRIDED_ND_ADDRESS_WALKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SNAW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SNAW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/snaw_pkg.sv
package snaw_pkg;

	localparam int DIM_SLOTS       = 4;
	localparam int IDX_W           = 24;
	localparam int OFS_W           = 32;
	localparam int APB_DW          = 32;
	localparam int APB_AW          = 5;
	localparam int NUM_DIMS_DEF    = 4;
	localparam int EXTENT_BITS_DEF = 24;
	localparam int OFFSET_BITS_DEF = 32;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} snaw_op_t;

	typedef enum logic [2:0] {
		REG_EXTENT_D0 = 3'd0,
		REG_EXTENT_D1 = 3'd1,
		REG_EXTENT_D2 = 3'd2,
		REG_EXTENT_D3 = 3'd3,
		REG_STRIDE_D0 = 3'd4,
		REG_STRIDE_D1 = 3'd5,
		REG_STRIDE_D2 = 3'd6,
		REG_STRIDE_D3 = 3'd7
	} snaw_reg_t;

	typedef struct packed {
		logic             opcode;
		logic [OFS_W-1:0] base_offset;
	} snaw_req_t;

	typedef struct packed {
		logic [OFS_W-1:0] element_offset;
		logic             wrapped_all;
		logic [IDX_W-1:0] index_d0;
		logic [IDX_W-1:0] index_d1;
		logic [IDX_W-1:0] index_d2;
		logic [IDX_W-1:0] index_d3;
	} snaw_rsp_t;

	// what a cell reports to the top level in the cycle it settles a step
	typedef struct packed {
		logic done;
		logic wrapped;
	} snaw_res_t;

endpackage

>>> rtl/strided_nd_address_walker_core.sv
// strided n-d address walker: an odometer of position counters over up to four
// dimensions, dimension 3 innermost, producing one element offset per request.
// request channel: req_valid / req_stall / req. opcode start loads base_offset
// and clears every counter; opcode advance steps the innermost counter.
// response channel: rsp_valid / rsp_stall / rsp, exactly one response per request.
// the response is registered and shows on rsp the cycle after the request is
// taken when no counter wraps. each wrap hands the step to the next outer cell
// through its carry register, so a request passes one carry register per
// wrapped dimension (at most NUM_DIMS - 1); a full wrap settles in the
// outermost cell, which registers no carry.
// throughput: one request per cycle while the innermost counter does not wrap
// and no response is stalled; while a carry travels along the cell chain, req_stall is high.
// a config write over the apb port holds req_stall high for the following cycle
// while each cell registers its rewind product (extent - 1) * stride.
// reset: counters and running offset clear, extents read 1, strides read 0.
// a stalled response holds rsp; a new request is taken only when the response
// register is free or being drained in the same cycle.
`include "strided_nd_address_walker_core_assert.svh"

module strided_nd_address_walker_core #(
	parameter int NUM_DIMS    = snaw_pkg::NUM_DIMS_DEF,
	parameter int EXTENT_BITS = snaw_pkg::EXTENT_BITS_DEF,
	parameter int OFFSET_BITS = snaw_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  snaw_pkg::snaw_req_t           req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output snaw_pkg::snaw_rsp_t           rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [snaw_pkg::APB_AW-1:0]   paddr,
	input  logic [snaw_pkg::APB_DW-1:0]   pwdata,
	output logic [snaw_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int SLOTS  = snaw_pkg::DIM_SLOTS;
	localparam int IDX_W  = snaw_pkg::IDX_W;
	localparam int OFS_W  = snaw_pkg::OFS_W;
	localparam int DW     = snaw_pkg::APB_DW;
	localparam int FIRST  = SLOTS - NUM_DIMS;

	logic [EXTENT_BITS-1:0] ext_q    [SLOTS];
	logic [OFFSET_BITS-1:0] stride_q [SLOTS];
	logic                   cfg_wr;
	logic                   hold_q;
	snaw_pkg::snaw_reg_t    reg_sel;

	logic [OFFSET_BITS-1:0] ofs_q;
	logic                   req_acc;
	logic                   start_acc;
	logic                   adv_acc;
	logic                   busy;

	logic [NUM_DIMS-1:0]    link_v;
	logic [OFFSET_BITS-1:0] link_ofs [NUM_DIMS];
	logic [EXTENT_BITS-1:0] idx_d    [NUM_DIMS];
	snaw_pkg::snaw_res_t    res      [NUM_DIMS];
	logic [OFFSET_BITS-1:0] res_ofs  [NUM_DIMS];
	logic [NUM_DIMS-1:0]    done_vec;
	logic                   done_any;
	logic                   done_wrap;
	logic [OFFSET_BITS-1:0] done_ofs;
	logic [IDX_W-1:0]       idx_slot [SLOTS];

	logic                   rsp_valid_q;
	snaw_pkg::snaw_rsp_t    rsp_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = snaw_pkg::snaw_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				ext_q[s]    <= EXTENT_BITS'(1);
				stride_q[s] <= '0;
			end
			hold_q <= 1'b0;
		end else begin
			hold_q <= cfg_wr;
			if (cfg_wr) begin
				unique case (reg_sel)
					snaw_pkg::REG_EXTENT_D0: ext_q[0] <= EXTENT_BITS'(pwdata[IDX_W-1:0]);
					snaw_pkg::REG_EXTENT_D1: ext_q[1] <= EXTENT_BITS'(pwdata[IDX_W-1:0]);
					snaw_pkg::REG_EXTENT_D2: ext_q[2] <= EXTENT_BITS'(pwdata[IDX_W-1:0]);
					snaw_pkg::REG_EXTENT_D3: ext_q[3] <= EXTENT_BITS'(pwdata[IDX_W-1:0]);
					snaw_pkg::REG_STRIDE_D0: stride_q[0] <= OFFSET_BITS'(pwdata[OFS_W-1:0]);
					snaw_pkg::REG_STRIDE_D1: stride_q[1] <= OFFSET_BITS'(pwdata[OFS_W-1:0]);
					snaw_pkg::REG_STRIDE_D2: stride_q[2] <= OFFSET_BITS'(pwdata[OFS_W-1:0]);
					snaw_pkg::REG_STRIDE_D3: stride_q[3] <= OFFSET_BITS'(pwdata[OFS_W-1:0]);
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_sel)
			snaw_pkg::REG_EXTENT_D0: prdata = DW'(ext_q[0]);
			snaw_pkg::REG_EXTENT_D1: prdata = DW'(ext_q[1]);
			snaw_pkg::REG_EXTENT_D2: prdata = DW'(ext_q[2]);
			snaw_pkg::REG_EXTENT_D3: prdata = DW'(ext_q[3]);
			snaw_pkg::REG_STRIDE_D0: prdata = DW'(stride_q[0]);
			snaw_pkg::REG_STRIDE_D1: prdata = DW'(stride_q[1]);
			snaw_pkg::REG_STRIDE_D2: prdata = DW'(stride_q[2]);
			snaw_pkg::REG_STRIDE_D3: prdata = DW'(stride_q[3]);
			default:                 prdata = '0;
		endcase
	end

	// request side
	assign busy      = |link_v;
	assign req_stall = busy || hold_q || (rsp_valid_q && rsp_stall);
	assign req_acc   = req_valid && !req_stall;
	assign start_acc = req_acc && (req.opcode == snaw_pkg::OP_START);
	assign adv_acc   = req_acc && (req.opcode == snaw_pkg::OP_ADVANCE);

	// cell chain, cell NUM_DIMS-1 is the innermost dimension
	for (genvar k = 0; k < NUM_DIMS; k++) begin : g_cell
		logic                   tok;
		logic [OFFSET_BITS-1:0] tok_ofs;

		if (k == NUM_DIMS - 1) begin : g_inner
			assign tok     = adv_acc;
			assign tok_ofs = ofs_q;
		end else begin : g_outer
			assign tok     = link_v[k+1];
			assign tok_ofs = link_ofs[k+1];
		end

		snaw_cell #(
			.EXTENT_BITS (EXTENT_BITS),
			.OFFSET_BITS (OFFSET_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.clear        (start_acc),
			.outermost    (k == 0),
			.tok_in       (tok),
			.ofs_in       (tok_ofs),
			.extent       (ext_q[FIRST+k]),
			.stride       (stride_q[FIRST+k]),
			.idx_d        (idx_d[k]),
			.res          (res[k]),
			.res_ofs      (res_ofs[k]),
			.carry_s1     (link_v[k]),
			.carry_ofs_s1 (link_ofs[k])
		);

		assign done_vec[k] = res[k].done;
	end

	// only the cell holding the step can finish it
	always_comb begin
		done_any  = 1'b0;
		done_wrap = 1'b0;
		done_ofs  = '0;
		for (int k = 0; k < NUM_DIMS; k++) begin
			done_any  = done_any | res[k].done;
			done_wrap = done_wrap | res[k].wrapped;
			done_ofs  = done_ofs | (res[k].done ? res_ofs[k] : '0);
		end
	end

	for (genvar s = 0; s < SLOTS; s++) begin : g_slot
		if (s >= FIRST) begin : g_used
			assign idx_slot[s] = IDX_W'(idx_d[s-FIRST]);
		end else begin : g_unused
			assign idx_slot[s] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (start_acc) begin
				ofs_q <= OFFSET_BITS'(req.base_offset);
			end else if (done_any) begin
				ofs_q <= done_ofs;
			end
			rsp_valid_q <= start_acc || done_any || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (start_acc) begin
			rsp_q.element_offset <= OFS_W'(OFFSET_BITS'(req.base_offset));
			rsp_q.wrapped_all    <= 1'b0;
			rsp_q.index_d0       <= '0;
			rsp_q.index_d1       <= '0;
			rsp_q.index_d2       <= '0;
			rsp_q.index_d3       <= '0;
		end else if (done_any) begin
			rsp_q.element_offset <= OFS_W'(done_ofs);
			rsp_q.wrapped_all    <= done_wrap;
			rsp_q.index_d0       <= idx_slot[0];
			rsp_q.index_d1       <= idx_slot[1];
			rsp_q.index_d2       <= idx_slot[2];
			rsp_q.index_d3       <= idx_slot[3];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SNAW_ASSERT_NOW(a_one_finisher, 1'b1, $onehot0(done_vec), "two cells finished one step")
	`SNAW_ASSERT_NOW(a_chain_rsp_free, busy, !rsp_valid_q, "carry in flight with response held")
	`SNAW_ASSERT_NEXT(a_start_rsp, start_acc, rsp_valid_q && !rsp_q.wrapped_all,
		"start request gave no clean response")

endmodule

>>> rtl/snaw_cell.sv
module snaw_cell #(
	parameter int EXTENT_BITS = snaw_pkg::EXTENT_BITS_DEF,
	parameter int OFFSET_BITS = snaw_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clear,
	input  logic                   outermost,
	input  logic                   tok_in,
	input  logic [OFFSET_BITS-1:0] ofs_in,
	input  logic [EXTENT_BITS-1:0] extent,
	input  logic [OFFSET_BITS-1:0] stride,
	output logic [EXTENT_BITS-1:0] idx_d,
	output snaw_pkg::snaw_res_t    res,
	output logic [OFFSET_BITS-1:0] res_ofs,
	output logic                   carry_s1,
	output logic [OFFSET_BITS-1:0] carry_ofs_s1
);

	logic [EXTENT_BITS-1:0]             idx_q;
	logic [EXTENT_BITS-1:0]             nxt;
	logic [EXTENT_BITS-1:0]             ext_eff;
	logic [EXTENT_BITS-1:0]             ext_m1;
	logic [EXTENT_BITS+OFFSET_BITS-1:0] prod;
	logic [OFFSET_BITS-1:0]             rewind_q;
	logic [OFFSET_BITS-1:0]             back_ofs;
	logic                               step_ok;

	// extent zero behaves as extent one
	assign ext_eff  = (extent == '0) ? EXTENT_BITS'(1) : extent;
	assign ext_m1   = ext_eff - EXTENT_BITS'(1);
	assign prod     = {{OFFSET_BITS{1'b0}}, ext_m1} * {{EXTENT_BITS{1'b0}}, stride};
	assign nxt      = idx_q + EXTENT_BITS'(1);
	assign step_ok  = (nxt != '0) && (nxt < ext_eff);
	assign back_ofs = ofs_in - rewind_q;

	always_comb begin
		if (clear) begin
			idx_d = '0;
		end else if (tok_in) begin
			idx_d = step_ok ? nxt : '0;
		end else begin
			idx_d = idx_q;
		end
	end

	always_comb begin
		res.done    = tok_in && (step_ok || outermost);
		res.wrapped = tok_in && !step_ok && outermost;
		res_ofs     = step_ok ? (ofs_in + stride) : back_ofs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			carry_s1 <= 1'b0;
			rewind_q <= '0;
		end else begin
			idx_q    <= idx_d;
			carry_s1 <= tok_in && !step_ok && !outermost;
			// rewind amount is registered from the product of the config
			rewind_q <= prod[OFFSET_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		carry_ofs_s1 <= back_ofs;
	end

endmodule
